// ===== rtl/prp_pkg.sv =====
// Package for the polyline equidistant resampler: widths, cap and the
// segment job record passed from the front end to the sample generator.
// No dependencies.
package prp_pkg;

  localparam int CoordW = 32;            // coordinate width, Q16.16
  localparam int DistW  = CoordW + 1;    // coordinate difference magnitude / length
  localparam int SqW    = 2 * DistW;     // sum of squares
  localparam int NumW   = SqW + 1;       // interpolation numerator
  localparam int SegCap = 62;            // samples per segment at most
  localparam int CntW   = 6;             // holds SegCap
  localparam int ItW    = 6;             // iteration counter, holds DistW-1

  typedef struct packed {
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic [DistW-1:0]         mag_x;
    logic [DistW-1:0]         mag_y;
    logic                     neg_x;
    logic                     neg_y;
    logic [DistW-1:0]         len;
    logic [CoordW-1:0]        r;
    logic [CoordW-1:0]        sp;
    logic [CntW-1:0]          count;
    logic                     tr;
    logic                     tail;
    logic signed [CoordW-1:0] tail_x;
    logic signed [CoordW-1:0] tail_y;
  } job_t;

endpackage

// ===== rtl/prp_if.sv =====
// Channel interfaces: vertex input, point output and spacing write.
// Depends on prp_pkg.
interface prp_vtx_if import prp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic                     first_of_line;
  logic                     last_of_line;
  modport source (output valid, vertex_x, vertex_y, first_of_line, last_of_line,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, first_of_line, last_of_line,
                  output ready);
endinterface

interface prp_pt_if import prp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic                     run_end;
  logic                     truncated;
  modport source (output valid, point_x, point_y, run_end, truncated, input ready);
  modport sink   (input valid, point_x, point_y, run_end, truncated, output ready);
endinterface

interface prp_cfg_if import prp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/prp_front.sv =====
// Front end: accepts vertices, keeps line state, computes segment length
// (square root) and sample count / remainder, and issues segment jobs.
// Depends on prp_pkg and prp_if.
module prp_front import prp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  prp_vtx_if.sink           vtx_in,
  input  logic [CoordW-1:0] spacing_i,
  output job_t              job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);

  typedef enum logic [2:0] {
    F_IDLE, F_MULX, F_MULY, F_SQRT, F_CHECK, F_DIV, F_FINISH, F_PUSH
  } fstate_e;

  fstate_e                  state_q;
  logic signed [CoordW-1:0] x_q, y_q, prev_x_q, prev_y_q;
  logic                     last_q, inside_q;
  logic [CoordW-1:0]        sp_q, dl_q, r_q;
  logic [DistW-1:0]         ax_q, ay_q;
  logic                     nx_q, ny_q;
  logic [SqW-1:0]           sum_q;
  logic [DistW-1:0]         root_q;
  logic [DistW+3:0]         rem_q;
  logic [ItW-1:0]           cnt_q;
  logic [DistW-1:0]         span_q, qt_q, drem_q;
  logic [CntW-1:0]          count_q;
  logic                     tr_q;
  job_t                     job_q;

  // vertex difference against the previous vertex
  logic [CoordW-1:0] sp_eff;
  logic signed [DistW-1:0] dx, dy;
  assign sp_eff = (spacing_i == '0) ? CoordW'(1) : spacing_i;
  assign dx = DistW'(vtx_in.vertex_x) - DistW'(prev_x_q);
  assign dy = DistW'(vtx_in.vertex_y) - DistW'(prev_y_q);

  // job of a first vertex: only the vertex itself
  job_t first_job;
  always_comb begin
    first_job        = '0;
    first_job.tail   = 1'b1;
    first_job.tail_x = vtx_in.vertex_x;
    first_job.tail_y = vtx_in.vertex_y;
  end

  // one square-root digit per cycle
  logic [DistW+3:0] rem_n, trial;
  assign rem_n = {rem_q[DistW+1:0], sum_q[SqW-1:SqW-2]};
  assign trial = {2'b00, root_q, 2'b01};

  // one quotient bit per cycle for span / spacing
  logic [DistW:0] drem_n;
  assign drem_n = {drem_q, span_q[DistW-1]};

  logic tail;
  assign tail = last_q && (dl_q != sp_q);

  assign vtx_in.ready = (state_q == F_IDLE);
  assign job_o        = job_q;
  assign job_valid_o  = (state_q == F_PUSH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      prev_x_q <= '0;
      prev_y_q <= '0;
      dl_q     <= '0;
      inside_q <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (vtx_in.valid) begin
            x_q    <= vtx_in.vertex_x;
            y_q    <= vtx_in.vertex_y;
            last_q <= vtx_in.last_of_line;
            sp_q   <= sp_eff;
            if (vtx_in.first_of_line || !inside_q) begin
              // first vertex of a line
              prev_x_q <= vtx_in.vertex_x;
              prev_y_q <= vtx_in.vertex_y;
              dl_q     <= sp_eff;
              inside_q <= !vtx_in.last_of_line;
              job_q    <= first_job;
              state_q  <= vtx_in.last_of_line ? F_IDLE : F_PUSH;
            end else begin
              nx_q    <= dx[DistW-1];
              ny_q    <= dy[DistW-1];
              ax_q    <= dx[DistW-1] ? DistW'(-dx) : DistW'(dx);
              ay_q    <= dy[DistW-1] ? DistW'(-dy) : DistW'(dy);
              state_q <= F_MULX;
            end
          end
        end
        F_MULX: begin
          sum_q   <= ax_q * ax_q;
          state_q <= F_MULY;
        end
        F_MULY: begin
          sum_q   <= sum_q + SqW'(ay_q * ay_q);
          root_q  <= '0;
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= F_SQRT;
        end
        F_SQRT: begin
          if (rem_n >= trial) begin
            rem_q  <= rem_n - trial;
            root_q <= {root_q[DistW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_n;
            root_q <= {root_q[DistW-2:0], 1'b0};
          end
          sum_q <= {sum_q[SqW-3:0], 2'b00};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ItW'(DistW - 1)) state_q <= F_CHECK;
        end
        F_CHECK: begin
          r_q     <= dl_q;
          count_q <= '0;
          tr_q    <= 1'b0;
          if (root_q == '0) begin
            state_q <= F_FINISH;
          end else if (DistW'(dl_q) > root_q) begin
            dl_q    <= dl_q - root_q[CoordW-1:0];
            state_q <= F_FINISH;
          end else begin
            span_q  <= root_q - DistW'(dl_q);
            qt_q    <= '0;
            drem_q  <= '0;
            cnt_q   <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          if (drem_n >= (DistW+1)'(sp_q)) begin
            drem_q <= DistW'(drem_n - (DistW+1)'(sp_q));
            qt_q   <= {qt_q[DistW-2:0], 1'b1};
          end else begin
            drem_q <= drem_n[DistW-1:0];
            qt_q   <= {qt_q[DistW-2:0], 1'b0};
          end
          span_q <= {span_q[DistW-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == ItW'(DistW - 1)) begin
            state_q <= F_FINISH;
          end
        end
        F_FINISH: begin
          // qt_q/drem_q final after division; count set in its last step
          job_q.base_x <= prev_x_q;
          job_q.base_y <= prev_y_q;
          job_q.mag_x  <= ax_q;
          job_q.mag_y  <= ay_q;
          job_q.neg_x  <= nx_q;
          job_q.neg_y  <= ny_q;
          job_q.len    <= root_q;
          job_q.r      <= r_q;
          job_q.sp     <= sp_q;
          job_q.count  <= count_q;
          job_q.tr     <= tr_q;
          job_q.tail   <= tail;
          job_q.tail_x <= x_q;
          job_q.tail_y <= y_q;
          prev_x_q     <= x_q;
          prev_y_q     <= y_q;
          if (last_q) inside_q <= 1'b0;
          state_q <= ((count_q != '0) || tail) ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (job_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
      // sample count and remainder once the last quotient bit is in
      if (state_q == F_DIV && cnt_q == ItW'(DistW - 1)) begin
        if (drem_n >= (DistW+1)'(sp_q)) begin
          if ({qt_q[DistW-2:0], 1'b1} >= DistW'(SegCap - 1)) count_q <= CntW'(SegCap);
          else count_q <= CntW'({qt_q[DistW-2:0], 1'b1} + 1'b1);
          tr_q <= ({qt_q[DistW-2:0], 1'b1} >= DistW'(SegCap));
          dl_q <= sp_q - (drem_n[CoordW-1:0] - sp_q);
        end else begin
          if ({qt_q[DistW-2:0], 1'b0} >= DistW'(SegCap - 1)) count_q <= CntW'(SegCap);
          else count_q <= CntW'({qt_q[DistW-2:0], 1'b0} + 1'b1);
          tr_q <= ({qt_q[DistW-2:0], 1'b0} >= DistW'(SegCap));
          dl_q <= sp_q - drem_n[CoordW-1:0];
        end
      end
    end
  end

  // checks on the front-end sequencing
  a_push_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> (job_q.count != '0 || job_q.tail)) else $error("empty job");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_q.count <= CntW'(SegCap)) else $error("count over cap");
  a_tr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_q.tr) |-> job_q.count == CntW'(SegCap))
    else $error("truncation without full count");

endmodule

// ===== rtl/prp_queue.sv =====
// Two-entry job queue between front end and sample generator.
// Depends on prp_pkg.
module prp_queue import prp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_o        = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/prp_back.sv =====
// Sample generator: interpolates the samples of one segment job, one
// divider pass per point, then any closing vertex; drives the output register.
// Depends on prp_pkg and prp_if.
module prp_back import prp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_t     job_i,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  prp_pt_if.source pt_out
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_OUT, B_TAIL} bstate_e;

  bstate_e                  state_q;
  job_t                     job_q;
  logic [DistW:0]           s_q;
  logic [CntW-1:0]          idx_q;
  logic [ItW-1:0]           cnt_q;
  logic [DistW-1:0]         remx_q, remy_q, shx_q, shy_q, qx_q, qy_q;
  logic                     ov_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic                     re_q, tr_out_q;

  // numerators mag * s + len/2
  logic [NumW-1:0] numx, numy;
  assign numx = NumW'(job_q.mag_x * s_q[DistW-1:0]) + NumW'(job_q.len >> 1);
  assign numy = NumW'(job_q.mag_y * s_q[DistW-1:0]) + NumW'(job_q.len >> 1);

  // one quotient bit per cycle on each axis
  logic [DistW:0] rnx, rny;
  logic           gx, gy;
  assign rnx = {remx_q, shx_q[DistW-1]};
  assign rny = {remy_q, shy_q[DistW-1]};
  assign gx  = rnx >= {1'b0, job_q.len};
  assign gy  = rny >= {1'b0, job_q.len};

  logic slot_free, last_smp, out_load;
  assign slot_free   = !ov_q || pt_out.ready;
  assign last_smp    = (idx_q + 1'b1 == job_q.count);
  assign out_load    = slot_free && (state_q == B_OUT || state_q == B_TAIL);
  assign job_ready_o = (state_q == B_IDLE);

  assign pt_out.valid     = ov_q;
  assign pt_out.point_x   = px_q;
  assign pt_out.point_y   = py_q;
  assign pt_out.run_end   = re_q;
  assign pt_out.truncated = tr_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      // output register: a new point wins over the transfer of the old one
      if (out_load) ov_q <= 1'b1;
      else if (pt_out.ready) ov_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            s_q     <= (DistW+1)'(job_i.r);
            idx_q   <= '0;
            state_q <= (job_i.count != '0) ? B_MUL : B_TAIL;
          end
        end
        B_MUL: begin
          remx_q  <= numx[NumW-2:DistW];
          remy_q  <= numy[NumW-2:DistW];
          shx_q   <= numx[DistW-1:0];
          shy_q   <= numy[DistW-1:0];
          qx_q    <= '0;
          qy_q    <= '0;
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          remx_q <= gx ? DistW'(rnx - {1'b0, job_q.len}) : rnx[DistW-1:0];
          remy_q <= gy ? DistW'(rny - {1'b0, job_q.len}) : rny[DistW-1:0];
          qx_q   <= {qx_q[DistW-2:0], gx};
          qy_q   <= {qy_q[DistW-2:0], gy};
          shx_q  <= {shx_q[DistW-2:0], 1'b0};
          shy_q  <= {shy_q[DistW-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == ItW'(DistW - 1)) state_q <= B_OUT;
        end
        B_OUT: begin
          if (slot_free) begin
            px_q     <= job_q.neg_x ? job_q.base_x - qx_q[CoordW-1:0]
                                    : job_q.base_x + qx_q[CoordW-1:0];
            py_q     <= job_q.neg_y ? job_q.base_y - qy_q[CoordW-1:0]
                                    : job_q.base_y + qy_q[CoordW-1:0];
            re_q     <= last_smp && !job_q.tail;
            tr_out_q <= job_q.tr;
            s_q      <= s_q + (DistW+1)'(job_q.sp);
            idx_q    <= idx_q + 1'b1;
            if (!last_smp)       state_q <= B_MUL;
            else if (job_q.tail) state_q <= B_TAIL;
            else                 state_q <= B_IDLE;
          end
        end
        B_TAIL: begin
          if (slot_free) begin
            px_q     <= job_q.tail_x;
            py_q     <= job_q.tail_y;
            re_q     <= 1'b1;
            tr_out_q <= job_q.tr;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // checks on the sample sequencing
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL || state_q == B_DIV || state_q == B_OUT) |-> idx_q < job_q.count)
    else $error("sample index past count");
  a_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_TAIL |-> job_q.tail) else $error("tail without request");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> job_q.len != '0) else $error("divide by zero length");

endmodule

// ===== rtl/polyline_equidistant_resampler_core.sv =====
// Polyline equidistant resampler, top level. Depends on prp_pkg, prp_if,
// prp_front, prp_queue and prp_back.
//
// Vertices (signed Q16.16) arrive on vtx_in; points spaced by the spacing
// register along each line leave on pt_out, run_end marking the last point
// of each vertex. The front end takes a vertex in the cycle it is offered
// when idle. A lone single-vertex line is only accepted; any other first
// vertex is accepted and its job then handed to the queue. Any other vertex
// goes through two squares and a 33-step square root, then, when samples
// fall on its segment, a 33-step division, then the job handoff when a job
// is issued, before the next vertex is accepted. A two-entry job queue then
// feeds the sample generator, which picks up a job, makes each interpolated
// point with one multiply and a 33-step divide (both axes in parallel) and
// then the vertex point if the job has one. Output is held in a register,
// so the sample generator keeps working while a point waits. The spacing
// register (reset 1.0) is written through cfg, always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// A spacing of 0 acts as 1 LSB.
module polyline_equidistant_resampler_core import prp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  prp_cfg_if.sink  cfg,
  prp_vtx_if.sink  vtx_in,
  prp_pt_if.source pt_out
);

  logic [CoordW-1:0] spacing_q;
  job_t              fjob, qjob;
  logic              fvalid, fready, qvalid, qready;

  // spacing register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= CoordW'(65536);
    end else if (cfg.valid) begin
      spacing_q <= cfg.data;
    end
  end

  prp_front u_front (
    .clk_i, .rst_ni, .vtx_in, .spacing_i(spacing_q),
    .job_o(fjob), .job_valid_o(fvalid), .job_ready_i(fready)
  );

  prp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(fjob), .push_valid_i(fvalid), .push_ready_o(fready),
    .pop_o(qjob), .pop_valid_o(qvalid), .pop_ready_i(qready)
  );

  prp_back u_back (
    .clk_i, .rst_ni, .job_i(qjob), .job_valid_i(qvalid), .job_ready_o(qready),
    .pt_out
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for polyline_equidistant_resampler_core: directed and
// random polylines, checked against a built-in model of the resampling.
// Depends on prp_pkg, prp_if and the RTL of the core.
module tb;
  import prp_pkg::*;

  localparam int DrainCycles = 120;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              run_end;
    logic              trunc;
  } point_t;

  logic clk_i;
  logic rst_ni;

  prp_cfg_if cfg ();
  prp_vtx_if vtx ();
  prp_pt_if  pt ();

  polyline_equidistant_resampler_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg),
    .vtx_in (vtx),
    .pt_out (pt)
  );

  // model state
  point_t              pending_pts[$];
  logic [31:0]         spacing_reg;
  logic signed [63:0]  last_x;
  logic signed [63:0]  last_y;
  logic [31:0]         arc_left;
  bit                  line_open;

  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_cnt;
  int     mismatches;
  int     vertices_sent;
  int     points_seen;
  int     trunc_seen;
  longint cycles;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d points pending", cycles, pending_pts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root[63:0];
  endfunction

  // point along one axis, offset rounded half away from zero
  function automatic logic [63:0] lerp_axis(input logic signed [63:0] p0,
                                            input logic signed [63:0] d,
                                            input logic [127:0] s,
                                            input logic [127:0] seg_len);
    logic [127:0] mag;
    logic [127:0] off;
    mag = d < 0 ? 128'(-d) : 128'(d);
    off = (mag * s + (seg_len >> 1)) / seg_len;
    return d < 0 ? p0 - off[63:0] : p0 + off[63:0];
  endfunction

  // expected points of one accepted vertex
  function automatic void predict_vertex(input logic [31:0] x, input logic [31:0] y,
                                         input bit f, input bit l);
    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [127:0]       ax;
    logic [127:0]       ay;
    logic [63:0]        sp;
    logic [63:0]        seg_len;
    logic [63:0]        r;
    logic [63:0]        span;
    logic [63:0]        total;
    logic [63:0]        emit;
    logic [127:0]       s;
    bit                 tr;
    point_t             pts[$];
    point_t             p;
    sx = {{32{x[31]}}, x};
    sy = {{32{y[31]}}, y};
    sp = spacing_reg == 0 ? 64'd1 : 64'(spacing_reg);
    tr = 1'b0;
    if (f || !line_open) begin
      last_x = sx;
      last_y = sy;
      arc_left = sp[31:0];
      if (l) begin
        line_open = 1'b0;
      end else begin
        line_open = 1'b1;
        pending_pts.insert(pending_pts.size(), '{x, y, 1'b1, 1'b0});
      end
      return;
    end
    dx = sx - last_x;
    dy = sy - last_y;
    ax = dx < 0 ? 128'(-dx) : 128'(dx);
    ay = dy < 0 ? 128'(-dy) : 128'(dy);
    seg_len = isqrt(ax * ax + ay * ay);
    r = 64'(arc_left);
    if (seg_len != 0) begin
      if (r > seg_len) begin
        arc_left = 32'(r - seg_len);
      end else begin
        span  = seg_len - r;
        total = span / sp + 1;
        tr    = total > SegCap;
        emit  = tr ? 64'(SegCap) : total;
        for (int i = 0; i < emit; i++) begin
          s = 128'(r) + 128'(i) * 128'(sp);
          p.x = 32'(lerp_axis(last_x, dx, s, 128'(seg_len)));
          p.y = 32'(lerp_axis(last_y, dy, s, 128'(seg_len)));
          p.run_end = 1'b0;
          p.trunc = 1'b0;
          pts.insert(pts.size(), p);
        end
        arc_left = 32'(sp - span % sp);
      end
    end
    last_x = sx;
    last_y = sy;
    if (l) begin
      if (64'(arc_left) != sp) pts.insert(pts.size(), '{x, y, 1'b0, 1'b0});
      line_open = 1'b0;
    end
    foreach (pts[k]) begin
      pts[k].trunc = tr;
      if (k == pts.size() - 1) pts[k].run_end = 1'b1;
      pending_pts.insert(pending_pts.size(), pts[k]);
    end
  endfunction

  // point receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      pt.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      pt.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare every point transfer with the oldest expectation
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && pt.valid && pt.ready) begin
      points_seen++;
      if (pt.truncated) trunc_seen++;
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point x=%h y=%h", pt.point_x, pt.point_y);
      end else begin
        want = pending_pts.pop_front();
        if (pt.point_x !== want.x || pt.point_y !== want.y ||
            pt.run_end !== want.run_end || pt.truncated !== want.trunc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: exp x=%h y=%h end=%b tr=%b, got x=%h y=%h end=%b tr=%b",
                     want.x, want.y, want.run_end, want.trunc,
                     pt.point_x, pt.point_y, pt.run_end, pt.truncated);
        end
      end
    end
  end

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input bit f, input bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid         <= 1'b1;
    vtx.vertex_x      <= x;
    vtx.vertex_y      <= y;
    vtx.first_of_line <= f;
    vtx.last_of_line  <= l;
    do @(posedge clk_i); while (!vtx.ready);
    predict_vertex(x, y, f, l);
    vertices_sent++;
  endtask

  // stop offering and let every pending point come out
  task automatic drain();
    vtx.valid <= 1'b0;
    wait (pending_pts.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_spacing(input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    spacing_reg = value;
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    // single-vertex line, then a missing first marker
    send_vertex(32'h0001_0000, 32'h0002_0000, 1'b1, 1'b1);
    send_vertex(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_vertex(32'h0003_0000, 32'h0004_0000, 1'b0, 1'b0);   // length 5.0
    send_vertex(32'h0003_0000, 32'h0004_0000, 1'b0, 1'b0);   // zero length
    send_vertex(32'h0003_8000, 32'h0004_0000, 1'b0, 1'b0);   // shorter than remainder
    send_vertex(32'h0005_8000, 32'h0004_0000, 1'b0, 1'b1);   // vertex 0.5 past last sample
    // early new line abandons an open one
    send_vertex(32'hFFFF_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_vertex(32'hFFFD_0000, 32'hFFFF_8000, 1'b0, 1'b0);
    send_vertex(32'h1000_0000, 32'h1000_0000, 1'b1, 1'b0);
    send_vertex(32'h1000_4000, 32'h1000_0000, 1'b0, 1'b1);   // last vertex after a remainder
    // coordinate extremes, truncated diagonal
    send_vertex(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_spacing_extremes();
    write_spacing(32'd1);
    send_vertex(32'd0, 32'd0, 1'b1, 1'b0);
    send_vertex(32'd3, 32'd4, 1'b0, 1'b0);
    send_vertex(32'd103, 32'hFFFF_FFFC, 1'b0, 1'b1);         // over the cap
    drain();
    write_spacing(32'd0);                                    // acts as 1
    send_vertex(32'd5, 32'd5, 1'b1, 1'b0);
    send_vertex(32'd9, 32'd2, 1'b0, 1'b1);
    drain();
    write_spacing(32'hFFFF_FFFF);
    send_vertex(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    drain();
    // spacing change in the middle of an open line
    write_spacing(32'h0002_0000);
    send_vertex(32'd0, 32'd0, 1'b1, 1'b0);
    send_vertex(32'h0003_0000, 32'd0, 1'b0, 1'b0);
    drain();
    write_spacing(32'h0000_8000);
    send_vertex(32'h0003_0000, 32'h0002_0000, 1'b0, 1'b1);
    drain();
  endtask

  function automatic logic [31:0] rand_step(input logic [31:0] sp);
    longint lim;
    int     mult;
    logic [31:0] mag;
    mult = ($urandom_range(99) < 3) ? $urandom_range(90, 20) : $urandom_range(4);
    lim = longint'(sp == 0 ? 1 : sp) * mult;
    if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
    mag = $urandom_range(0, 32'(lim));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic test_random_lines(input int n_items, input int idle_pct, input int stall_pct);
    logic [31:0] x;
    logic [31:0] y;
    int          nv;
    int          sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        // noise: lone vertex with random markers
        send_vertex($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        nv = $urandom_range(7, 2);
        x = $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000);
        y = $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000);
        for (int i = 0; i < nv; i++) begin
          if (i > 0) begin
            x = x + rand_step(spacing_reg);
            y = y + rand_step(spacing_reg);
          end
          send_vertex(x, y, i == 0, i == nv - 1);
        end
        sent += nv;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_spacing(32'h0000_4000);
    hold_cnt <= 800;
    send_vertex(32'd0, 32'd0, 1'b1, 1'b0);
    for (int i = 1; i <= 8; i++)
      send_vertex(32'(i * 32'h0001_0000), 32'(i * 32'h0000_8000), 1'b0, 1'b0);
    // sender waits for every point before the line goes on
    vtx.valid <= 1'b0;
    wait (pending_pts.size() == 0);
    @(posedge clk_i);
    send_vertex(32'h000A_0000, 32'hFFFF_0000, 1'b0, 1'b0);
    send_vertex(32'h000B_0000, 32'hFFFE_0000, 1'b0, 1'b1);
    drain();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.data       <= '0;
    vtx.valid      <= 1'b0;
    vtx.vertex_x   <= '0;
    vtx.vertex_y   <= '0;
    vtx.first_of_line <= 1'b0;
    vtx.last_of_line  <= 1'b0;
    spacing_reg    = 32'h0001_0000;
    last_x         = '0;
    last_y         = '0;
    arc_left       = '0;
    line_open      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cnt       = 0;
    mismatches     = 0;
    vertices_sent  = 0;
    points_seen    = 0;
    trunc_seen     = 0;
    cycles         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_spacing_extremes();
    write_spacing(32'h0001_8000);
    test_random_lines(70, 0, 0);
    write_spacing($urandom_range(300, 2));
    test_random_lines(70, 69, 0);
    write_spacing(32'hFFFF_FFFF);
    test_random_lines(40, 0, 69);
    write_spacing($urandom);
    test_random_lines(40, 13, 13);
    write_spacing(32'h0000_0100);
    test_random_lines(40, 13, 13);
    test_backpressure();

    $display("covered %0d vertices, %0d points (%0d truncated), spacing from 0 to max",
             vertices_sent, points_seen, trunc_seen);
    $display("idle/stall phases and a long output hold-off; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
